>>> rtl/transactional_ring_fifo_macros.svh
// assertion macros for the transactional ring fifo
`ifndef TRANSACTIONAL_RING_FIFO_MACROS_SVH
`define TRANSACTIONAL_RING_FIFO_MACROS_SVH

// condition implies consequence in the same cycle
`define TRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define TRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/trfifo_pkg.sv
package trfifo_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned LIMIT_W  = 11;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam t_mode MODE_PARTIAL = 2'd0;
    localparam t_mode MODE_COMMIT  = 2'd1;
    localparam t_mode MODE_PEEK    = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

endpackage

>>> rtl/transactional_ring_fifo.sv
// Ring FIFO of up to DEPTH-1 words with a partial and a committed pointer on each side. Every
// input transaction moves at most one word (put or get) and yields exactly one output transaction
// carrying the word read, a status and the free space and data count after the step.
// Transactions are taken one per cycle while the output drains; a result passes from the
// accept cycle through the pending stage, which holds the registered read of the word store,
// and then the output register. One pending result and one output result can be held; with
// both held and the output stalled, the input stalls. The
// store is one synchronous memory with one write and one read port, and all pointer updates
// are done in the accept cycle. Writing the limit register (clamped to 2..DEPTH) clears all
// pointers at once; the store itself is never cleared. Write the limit only while idle.
`include "transactional_ring_fifo_macros.svh"

module transactional_ring_fifo #(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [trfifo_pkg::LIMIT_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [trfifo_pkg::VALUE_W-1:0]      i_value,
    input  trfifo_pkg::t_mode                   i_mode,
    input  logic                                i_last_of_call,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [trfifo_pkg::VALUE_W-1:0]      o_read_value,
    output trfifo_pkg::t_status                 o_status,
    output logic [trfifo_pkg::COUNT_W-1:0]      o_free_space,
    output logic [trfifo_pkg::COUNT_W-1:0]      o_data_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam int unsigned RESET_LIMIT = (DEPTH < 1024) ? DEPTH : 1024;

    function automatic logic [LW-1:0] words_between(
        input logic [PW-1:0] head,
        input logic [PW-1:0] tail,
        input logic [LW-1:0] lim
    );
        logic [LW-1:0] he;
        logic [LW-1:0] te;
        he = LW'(head);
        te = LW'(tail);
        return (head >= tail) ? (he - te) : (lim - te + he);
    endfunction

    function automatic logic [PW-1:0] advance(
        input logic [PW-1:0] p,
        input logic [LW-1:0] lim
    );
        logic [LW-1:0] nxt;
        nxt = LW'(p) + LW'(1);
        return (nxt >= lim) ? '0 : nxt[PW-1:0];
    endfunction

    // state
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic [LW-1:0]         r_limit;
    logic [PW-1:0]         r_wp, r_wc, r_rcur, r_rp, r_rc;
    logic [PW-1:0]         n_wp, n_wc, n_rcur, n_rp, n_rc;

    // stage between accept and output
    logic                  r_p_valid;
    trfifo_pkg::t_status   r_p_status;
    logic                  r_p_rd_ok;

    // output register
    logic                               r_o_valid;
    logic [trfifo_pkg::VALUE_W-1:0]     r_o_read_value;
    trfifo_pkg::t_status                r_o_status;
    logic [trfifo_pkg::COUNT_W-1:0]     r_o_free_space;
    logic [trfifo_pkg::COUNT_W-1:0]     r_o_data_count;

    logic                  w_accept;
    logic                  w_p_move;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_wr_en;
    logic                  w_rd_en;
    trfifo_pkg::t_status   n_status;
    logic [PW-1:0]         w_wp_adv;
    logic [PW-1:0]         w_rcur_adv;
    logic [LW-1:0]         w_used;
    logic [LW-1:0]         w_free;
    logic [LW-1:0]         w_count;
    logic [31:0]           w_cfg32;
    logic [31:0]           w_lim32;
    logic [63:0]           w_value64;
    logic [63:0]           w_rd64;

    assign w_p_move   = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_p_valid && !w_p_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_wp_adv   = advance(r_wp, r_limit);
    assign w_rcur_adv = advance(r_rcur, r_limit);
    assign w_full     = (words_between(r_wp, r_rc, r_limit) == (r_limit - LW'(1)));
    assign w_empty    = (r_wc == r_rcur);

    always_comb begin
        n_wp     = r_wp;
        n_wc     = r_wc;
        n_rcur   = r_rcur;
        n_rp     = r_rp;
        n_rc     = r_rc;
        n_status = trfifo_pkg::STATUS_OK;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        if (w_accept) begin
            if (i_command == trfifo_pkg::CMD_PUT) begin
                if (w_full) begin
                    n_status = trfifo_pkg::STATUS_FULL;
                end else begin
                    w_wr_en = 1'b1;
                    n_wp    = w_wp_adv;
                    if (i_last_of_call && (i_mode == trfifo_pkg::MODE_COMMIT)) begin
                        n_wc = w_wp_adv;
                    end
                end
            end else begin
                if (w_empty) begin
                    n_status = trfifo_pkg::STATUS_EMPTY;
                end else begin
                    w_rd_en = 1'b1;
                    n_rcur  = w_rcur_adv;
                    if (i_last_of_call) begin
                        if (i_mode == trfifo_pkg::MODE_PEEK) begin
                            n_rcur = r_rp;
                        end else begin
                            n_rp = w_rcur_adv;
                            if (i_mode == trfifo_pkg::MODE_COMMIT) begin
                                n_rc = w_rcur_adv;
                            end
                        end
                    end
                end
            end
        end
    end

    // word store
    assign w_value64 = 64'(i_value);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wp] <= w_value64[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_mem_q <= r_mem[r_rcur];
        end
    end

    // limit register and pointers
    assign w_cfg32 = 32'(i_cfg_data);

    always_comb begin
        if (w_cfg32 < 32'd2) begin
            w_lim32 = 32'd2;
        end else if (w_cfg32 > 32'(DEPTH)) begin
            w_lim32 = 32'(DEPTH);
        end else begin
            w_lim32 = w_cfg32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LW'(RESET_LIMIT);
            r_wp    <= '0;
            r_wc    <= '0;
            r_rcur  <= '0;
            r_rp    <= '0;
            r_rc    <= '0;
        end else if (i_cfg_we) begin
            r_limit <= w_lim32[LW-1:0];
            r_wp    <= '0;
            r_wc    <= '0;
            r_rcur  <= '0;
            r_rp    <= '0;
            r_rc    <= '0;
        end else begin
            r_wp    <= n_wp;
            r_wc    <= n_wc;
            r_rcur  <= n_rcur;
            r_rp    <= n_rp;
            r_rc    <= n_rc;
        end
    end

    // pointers already hold the post-step values while the stage waits
    assign w_used  = words_between(r_wp, r_rc, r_limit);
    assign w_free  = r_limit - w_used - LW'(1);
    assign w_count = words_between(r_wc, r_rp, r_limit);
    assign w_rd64  = 64'(r_mem_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_accept) begin
            r_p_valid <= 1'b1;
        end else if (w_p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_status <= n_status;
            r_p_rd_ok  <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_move) begin
            r_o_read_value <= r_p_rd_ok ? w_rd64[trfifo_pkg::VALUE_W-1:0] : '0;
            r_o_status     <= r_p_status;
            r_o_free_space <= trfifo_pkg::COUNT_W'(w_free);
            r_o_data_count <= trfifo_pkg::COUNT_W'(w_count);
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_read_value = r_o_read_value;
    assign o_status     = r_o_status;
    assign o_free_space = r_o_free_space;
    assign o_data_count = r_o_data_count;

    // checks
    `TRF_ASSERT_SAME(a_ptr_in_range, i_clk, i_rst_n, 1'b1,
        (LW'(r_wp) < r_limit) && (LW'(r_rcur) < r_limit),
        "pointer beyond limit")
    `TRF_ASSERT_SAME(a_refused_no_data, i_clk, i_rst_n,
        r_o_valid && (r_o_status != trfifo_pkg::STATUS_OK), r_o_read_value == '0,
        "refused transaction carries data")
    `TRF_ASSERT_NEXT(a_full_holds_wp, i_clk, i_rst_n,
        w_accept && !i_cfg_we && (i_command == trfifo_pkg::CMD_PUT) && w_full,
        $stable(r_wp) && $stable(r_wc), "refused put moved write pointers")
    `TRF_ASSERT_SAME(a_counts_fit, i_clk, i_rst_n, 1'b1,
        ((LW + 1)'(w_free) + (LW + 1)'(w_count)) < (LW + 1)'(r_limit),
        "free space and data count exceed limit")
    `TRF_ASSERT_NEXT(a_stage_kept, i_clk, i_rst_n, r_p_valid && !w_p_move,
        r_p_valid && $stable(r_p_status), "pending result lost under stall")

endmodule

>>> bench/tb_transactional_ring_fifo.sv
`timescale 1ns / 1ps

module tb_transactional_ring_fifo;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned DATA_WIDTH = 32;
    localparam trfifo_pkg::t_mode MODE_PARTIAL_ALT = 2'd3;

    typedef struct packed {
        logic [trfifo_pkg::VALUE_W-1:0] read_value;
        trfifo_pkg::t_status            status;
        logic [trfifo_pkg::COUNT_W-1:0] free_space;
        logic [trfifo_pkg::COUNT_W-1:0] data_count;
    } t_fifo_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [trfifo_pkg::LIMIT_W-1:0]  i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_command = trfifo_pkg::CMD_PUT;
    logic [trfifo_pkg::VALUE_W-1:0]  i_value = '0;
    trfifo_pkg::t_mode               i_mode = trfifo_pkg::MODE_PARTIAL;
    logic                            i_last_of_call = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [trfifo_pkg::VALUE_W-1:0]  o_read_value;
    trfifo_pkg::t_status             o_status;
    logic [trfifo_pkg::COUNT_W-1:0]  o_free_space;
    logic [trfifo_pkg::COUNT_W-1:0]  o_data_count;

    transactional_ring_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_mode         (i_mode),
        .i_last_of_call (i_last_of_call),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_free_space   (o_free_space),
        .o_data_count   (o_data_count)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the ring state
    logic [trfifo_pkg::VALUE_W-1:0] word_mem [DEPTH];
    int unsigned        ring_limit = DEPTH;
    int unsigned        wr_part = 0;
    int unsigned        wr_comm = 0;
    int unsigned        rd_cur = 0;
    int unsigned        rd_part = 0;
    int unsigned        rd_comm = 0;

    t_fifo_result awaited_results [$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;
    int           hold_left = 0;

    function automatic int unsigned ring_span(int unsigned head, int unsigned tail);
        return (head >= tail) ? head - tail : ring_limit - tail + head;
    endfunction

    function automatic int unsigned ring_free(int unsigned head, int unsigned tail);
        return ring_limit - ring_span(head, tail) - 1;
    endfunction

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_limit) ? 0 : p + 1;
    endfunction

    function automatic t_fifo_result fifo_step(logic cmd,
                                               logic [trfifo_pkg::VALUE_W-1:0] val,
                                               trfifo_pkg::t_mode md, logic last);
        t_fifo_result r;
        r.read_value = '0;
        r.status = trfifo_pkg::STATUS_OK;
        if (cmd == trfifo_pkg::CMD_PUT) begin
            if (ring_free(wr_part, rd_comm) == 0) begin
                r.status = trfifo_pkg::STATUS_FULL;
            end else begin
                word_mem[wr_part] = val;
                wr_part = ring_next(wr_part);
                if (last && md == trfifo_pkg::MODE_COMMIT) wr_comm = wr_part;
            end
        end else begin
            if (ring_span(wr_comm, rd_cur) == 0) begin
                r.status = trfifo_pkg::STATUS_EMPTY;
            end else begin
                r.read_value = word_mem[rd_cur];
                rd_cur = ring_next(rd_cur);
                if (last) begin
                    if (md == trfifo_pkg::MODE_PEEK) begin
                        rd_cur = rd_part;
                    end else begin
                        rd_part = rd_cur;
                        if (md == trfifo_pkg::MODE_COMMIT) rd_comm = rd_cur;
                    end
                end
            end
        end
        r.free_space = trfifo_pkg::COUNT_W'(ring_free(wr_part, rd_comm));
        r.data_count = trfifo_pkg::COUNT_W'(ring_span(wr_comm, rd_part));
        return r;
    endfunction

    function automatic trfifo_pkg::t_mode pick_mode();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 5) return trfifo_pkg::MODE_COMMIT;
        if (r < 7) return trfifo_pkg::MODE_PARTIAL;
        if (r < 9) return trfifo_pkg::MODE_PEEK;
        return MODE_PARTIAL_ALT;
    endfunction

    // receiver: long hold-off when asked, random stalls otherwise while idle_on is set
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(99) < 35) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result check, sampled mid-cycle
    always @(negedge i_clk) begin
        t_fifo_result want;
        t_fifo_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_read_value, o_status, o_free_space, o_data_count};
            if (awaited_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected transaction: value %h status %0d free %0d count %0d",
                             got.read_value, got.status, got.free_space, got.data_count);
                end
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch: exp value %h status %0d free %0d count %0d",
                                 want.read_value, want.status, want.free_space,
                                 want.data_count);
                        $display("          got value %h status %0d free %0d count %0d",
                                 got.read_value, got.status, got.free_space, got.data_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [trfifo_pkg::VALUE_W-1:0] val,
                             input trfifo_pkg::t_mode md, input logic last);
        if (idle_on && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_value <= val;
        i_mode <= md;
        i_last_of_call <= last;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        awaited_results.push_back(fifo_step(cmd, val, md, last));
        @(posedge i_clk);
    endtask

    task automatic send_call(input logic cmd, input int len, input trfifo_pkg::t_mode md);
        for (int k = 0; k < len; k++) begin
            send_word(cmd, $urandom(), md, k == len - 1);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [trfifo_pkg::LIMIT_W-1:0] v);
        int unsigned clamped;
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        clamped = v;
        if (clamped < 2) clamped = 2;
        if (clamped > DEPTH) clamped = DEPTH;
        ring_limit = clamped;
        wr_part = 0;
        wr_comm = 0;
        rd_cur = 0;
        rd_part = 0;
        rd_comm = 0;
    endtask

    task automatic test_directed();
        send_word(trfifo_pkg::CMD_GET, 32'h0000_0000, trfifo_pkg::MODE_PARTIAL, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'h0000_0000, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'hFFFF_FFFF, trfifo_pkg::MODE_PARTIAL, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'hFFFF_FFFF, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0000_0000, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'hA5A5_A5A5, trfifo_pkg::MODE_PEEK, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'h5A5A_5A5A, MODE_PARTIAL_ALT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'h1234_5678, trfifo_pkg::MODE_COMMIT, 1'b0);
        send_word(trfifo_pkg::CMD_PUT, 32'h8765_4321, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_PARTIAL, 1'b0);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_PEEK, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_PARTIAL, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, MODE_PARTIAL_ALT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_COMMIT, 1'b1);
        // value below range clamps to two slots
        write_limit(11'd0);
        send_word(trfifo_pkg::CMD_PUT, 32'hDEAD_BEEF, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'hCAFE_F00D, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'h0F0F_0F0F, trfifo_pkg::MODE_COMMIT, 1'b1);
        write_limit(11'd1);
        send_word(trfifo_pkg::CMD_PUT, 32'hF0F0_F0F0, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_PEEK, 1'b1);
        // value above range clamps to the full store
        write_limit(11'h7FF);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_COMMIT, 1'b1);
        send_word(trfifo_pkg::CMD_PUT, 32'h1111_1111, trfifo_pkg::MODE_COMMIT, 1'b1);
        write_limit(11'd1024);
        send_word(trfifo_pkg::CMD_GET, 32'h0, trfifo_pkg::MODE_COMMIT, 1'b1);
    endtask

    task automatic test_random_calls(input logic [trfifo_pkg::LIMIT_W-1:0] lim, input int n,
                                     input int put_pct);
        int   sent;
        int   len;
        logic cmd;
        write_limit(lim);
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                cmd = ($urandom_range(99) < put_pct) ? trfifo_pkg::CMD_PUT
                                                     : trfifo_pkg::CMD_GET;
                len = $urandom_range(1, 4);
                send_call(cmd, len, pick_mode());
                sent += len;
            end else begin
                send_word(1'($urandom()), $urandom(), trfifo_pkg::t_mode'($urandom_range(3)),
                          1'($urandom()));
                sent++;
            end
        end
    endtask

    task automatic test_back_pressure();
        write_limit(11'd32);
        hold_left = 200;
        for (int k = 0; k < 40; k++) begin
            send_word(trfifo_pkg::CMD_PUT, $urandom(), trfifo_pkg::MODE_COMMIT, 1'b1);
        end
        for (int k = 0; k < 10; k++) begin
            send_call(trfifo_pkg::CMD_GET, 2, trfifo_pkg::MODE_COMMIT);
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_calls(11'd7, 150, 50);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_calls(11'd2, 90, 50);
        test_random_calls(11'd3, 90, 50);
        test_random_calls(11'd5, 90, 55);
        test_random_calls(11'd16, 90, 60);
        test_random_calls(11'd1024, 90, 75);
        test_random_calls(11'd1024, 90, 30);
        test_random_calls(11'($urandom_range(2, 40)), 90, 50);
        test_random_calls(11'($urandom_range(2047)), 90, 50);
        test_back_pressure();
        test_steady_stream();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
